// ----- sv/bds_pkg.sv -----
`default_nettype none
package bds_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned ScaleW = 11;
  localparam int unsigned ScoreScale = 2000;

  localparam logic [StatW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatW-1:0] STATUS_TOO_SHORT = 2'd1;
  localparam logic [StatW-1:0] STATUS_TOO_LONG  = 2'd2;

  localparam logic FUNC_REF   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic             func;
    logic [CharW-1:0] ch;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [StatW-1:0]  status;
  } res_t;

  typedef struct packed {
    logic shift;
    logic hit_en;
    logic cnt_clr;
    logic drain;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SCALE,
    ST_DIVIDE
  } state_e;

endpackage
`default_nettype wire

// ----- sv/bds_cell.sv -----
`default_nettype none
module bds_cell
  import bds_pkg::*;
#(
  parameter int unsigned CW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_ctl_t        ctl_i,
  input  wire logic [CharW-1:0] ch_i,
  input  wire logic             vld_i,
  input  wire logic [CharW-1:0] nb_ch_i,
  input  wire logic             nb_vld_i,
  input  wire logic [CharW-1:0] first_i,
  input  wire logic [CharW-1:0] second_i,
  input  wire logic [CW-1:0]    cnt_i,
  output logic      [CharW-1:0] ch_o,
  output logic                  vld_o,
  output logic      [CW-1:0]    cnt_o
);

  logic [CharW-1:0] ch_q, ch_d;
  logic             vld_q, vld_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             hit;

  assign hit = ctl_i.hit_en && nb_vld_i && (nb_ch_i == first_i) && (ch_q == second_i);

  always_comb begin
    ch_d  = ch_q;
    vld_d = vld_q;
    cnt_d = cnt_q;
    if (ctl_i.shift) begin
      ch_d  = ch_i;
      vld_d = vld_i;
    end
    if (ctl_i.cnt_clr) begin
      cnt_d = '0;
    end else if (ctl_i.drain) begin
      cnt_d = cnt_i;
    end else if (hit) begin
      cnt_d = cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
    end
  end

  assign ch_o  = ch_q;
  assign vld_o = vld_q;
  assign cnt_o = cnt_q;

endmodule
`default_nettype wire

// ----- sv/bds_div.sv -----
`default_nettype none
module bds_div
  import bds_pkg::*;
#(
  parameter int unsigned NW = 23,
  parameter int unsigned DW = 7
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic      [NW-1:0] quotient_o
);

  localparam int unsigned KW = $clog2(NW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [KW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[NW-2:0], ge};
      rem_d = ge ? DW'(rem_sh - {1'b0, dvs_q}) : DW'(rem_sh);
      cnt_d = cnt_q + KW'(1);
      if (cnt_q == KW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ----- sv/bigram_dice_similarity.sv -----
// Letter-pair similarity of a stored reference string and a streamed query.
// Input: one character beat per accepted command (start high, busy low),
// cmd_i.func selects reference (0) or query (1), cmd_i.last ends the string.
// Reference characters shift into a row of MAX_LEN cells, newest first; each
// query character broadcasts the pair (previous, current) to every cell, and
// each cell counts hits of its own stored pair in a local counter.
// Busy stays low between the characters of a string.
// After the query's last beat busy rises: the cell counters drain through the
// row into an accumulator; if the status is ok, the total is then scaled by
// 2000 and divided by the pair count in a bit-serial divider (one cycle per
// quotient bit, about 2*log2(MAX_LEN)+11 bits); else the score is zero.
// The result beat then shows on res_o with res_valid_o high for exactly one
// cycle. The receiver cannot stall; the result must be taken in that cycle.
// Reset clears the stored reference, the query state and all counters.
`default_nettype none
module bigram_dice_similarity
  import bds_pkg::*;
#(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t cmd_i,
  output logic      res_valid_o,
  output res_t      res_o
);

  localparam int unsigned CW = $clog2(MAX_LEN);
  localparam int unsigned MW = $clog2((MAX_LEN - 1) * (MAX_LEN - 1) + 1);
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned DW = $clog2(2 * MAX_LEN - 1);
  localparam int unsigned NW = MW + ScaleW;

  state_e           state_q, state_d;
  logic [LW-1:0]    ref_len_q, ref_len_d;
  logic             ref_done_q, ref_done_d;
  logic             ref_ovf_q, ref_ovf_d;
  logic [CharW-1:0] prev_q, prev_d;
  logic [LW-1:0]    q_len_q, q_len_d;
  logic             q_ovf_q, q_ovf_d;
  logic [MW-1:0]    acc_q, acc_d;
  logic [LW-1:0]    drain_cnt_q, drain_cnt_d;
  logic [StatW-1:0] stat_q, stat_d;
  logic [DW-1:0]    pairs_q, pairs_d;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;

  cell_ctl_t        ctl;
  logic             accept;
  logic             restart;
  logic [LW-1:0]    len_eff;
  logic [LW-1:0]    ql_next;
  logic             qovf_next;
  logic             div_start;
  logic             div_done;
  logic [NW-1:0]    dividend;
  logic [NW-1:0]    quotient;

  logic [CharW-1:0] ch_w  [MAX_LEN];
  logic             vld_w [MAX_LEN];
  logic [CW-1:0]    cnt_w [MAX_LEN];

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  genvar gi;
  generate
    for (gi = 0; gi < MAX_LEN; gi++) begin : g_cell
      logic [CharW-1:0] in_ch;
      logic             in_vld;
      logic [CharW-1:0] nb_ch;
      logic             nb_vld;
      logic [CW-1:0]    nb_cnt;
      if (gi == 0) begin : g_head
        assign in_ch  = cmd_i.ch;
        assign in_vld = 1'b1;
      end else begin : g_body
        assign in_ch  = ch_w[gi-1];
        assign in_vld = vld_w[gi-1] && !restart;
      end
      if (gi == MAX_LEN - 1) begin : g_tail
        assign nb_ch  = '0;
        assign nb_vld = 1'b0;
        assign nb_cnt = '0;
      end else begin : g_link
        assign nb_ch  = ch_w[gi+1];
        assign nb_vld = vld_w[gi+1];
        assign nb_cnt = cnt_w[gi+1];
      end
      bds_cell #(
        .CW(CW)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctl_i    (ctl),
        .ch_i     (in_ch),
        .vld_i    (in_vld),
        .nb_ch_i  (nb_ch),
        .nb_vld_i (nb_vld),
        .first_i  (prev_q),
        .second_i (cmd_i.ch),
        .cnt_i    (nb_cnt),
        .ch_o     (ch_w[gi]),
        .vld_o    (vld_w[gi]),
        .cnt_o    (cnt_w[gi])
      );
    end
  endgenerate

  assign dividend = NW'(acc_q) * NW'(ScoreScale);

  bds_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (pairs_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign restart   = ref_done_q;
  assign len_eff   = restart ? '0 : ref_len_q;
  assign qovf_next = q_ovf_q || (q_len_q == LW'(MAX_LEN));
  assign ql_next   = (q_len_q < LW'(MAX_LEN)) ? q_len_q + LW'(1) : q_len_q;

  always_comb begin
    state_d     = state_q;
    ref_len_d   = ref_len_q;
    ref_done_d  = ref_done_q;
    ref_ovf_d   = ref_ovf_q;
    prev_d      = prev_q;
    q_len_d     = q_len_q;
    q_ovf_d     = q_ovf_q;
    acc_d       = acc_q;
    drain_cnt_d = drain_cnt_q;
    stat_d      = stat_q;
    pairs_d     = pairs_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ctl         = '0;
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i.func == FUNC_REF) begin
          ctl.cnt_clr = 1'b1;
          prev_d      = '0;
          q_len_d     = '0;
          q_ovf_d     = 1'b0;
          ref_done_d  = cmd_i.last;
          if (len_eff < LW'(MAX_LEN)) begin
            ctl.shift = 1'b1;
            ref_len_d = len_eff + LW'(1);
            ref_ovf_d = restart ? 1'b0 : ref_ovf_q;
          end else begin
            ref_len_d = len_eff;
            ref_ovf_d = 1'b1;
          end
        end else if (accept) begin
          if (q_len_q < LW'(MAX_LEN)) begin
            ctl.hit_en = (q_len_q != '0);
            prev_d     = cmd_i.ch;
          end
          q_len_d = ql_next;
          q_ovf_d = qovf_next;
          if (cmd_i.last) begin
            if (ref_len_q < LW'(2) || ql_next < LW'(2)) begin
              stat_d = STATUS_TOO_SHORT;
            end else if (ref_ovf_q || qovf_next) begin
              stat_d = STATUS_TOO_LONG;
            end else begin
              stat_d = STATUS_OK;
            end
            pairs_d     = DW'({1'b0, ref_len_q} + {1'b0, ql_next} - (LW + 1)'(2));
            prev_d      = '0;
            q_len_d     = '0;
            q_ovf_d     = 1'b0;
            acc_d       = '0;
            drain_cnt_d = '0;
            state_d     = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        ctl.drain   = 1'b1;
        acc_d       = acc_q + MW'(cnt_w[0]);
        drain_cnt_d = drain_cnt_q + LW'(1);
        if (drain_cnt_q == LW'(MAX_LEN - 1)) begin
          if (stat_q == STATUS_OK) begin
            state_d = ST_SCALE;
          end else begin
            res_valid_d  = 1'b1;
            res_d.score  = '0;
            res_d.status = stat_q;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_SCALE: begin
        div_start = 1'b1;
        state_d   = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          res_valid_d  = 1'b1;
          res_d.status = STATUS_OK;
          res_d.score  = (32'(quotient) > 32'd65535) ? '1 : ScoreW'(quotient);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ref_len_q   <= '0;
      ref_done_q  <= 1'b0;
      ref_ovf_q   <= 1'b0;
      prev_q      <= '0;
      q_len_q     <= '0;
      q_ovf_q     <= 1'b0;
      acc_q       <= '0;
      drain_cnt_q <= '0;
      stat_q      <= STATUS_OK;
      pairs_q     <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      ref_len_q   <= ref_len_d;
      ref_done_q  <= ref_done_d;
      ref_ovf_q   <= ref_ovf_d;
      prev_q      <= prev_d;
      q_len_q     <= q_len_d;
      q_ovf_q     <= q_ovf_d;
      acc_q       <= acc_d;
      drain_cnt_q <= drain_cnt_d;
      stat_q      <= stat_d;
      pairs_q     <= pairs_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import bds_pkg::*;

  localparam int unsigned MaxLen       = 64;
  localparam int          ItemTarget   = 900;
  localparam int          StallLimit   = 4000;
  localparam int          SettleCycles = 150;

  localparam logic [CharW-1:0] CH_A = 8'h61;
  localparam logic [CharW-1:0] CH_B = 8'h62;
  localparam logic [CharW-1:0] CH_P = 8'h70;
  localparam logic [CharW-1:0] CH_Q = 8'h71;
  localparam logic [CharW-1:0] CH_R = 8'h72;
  localparam logic [CharW-1:0] CH_X = 8'h78;
  localparam logic [CharW-1:0] CH_Y = 8'h79;
  localparam logic [CharW-1:0] CH_MIN = 8'h01;
  localparam logic [CharW-1:0] CH_MAX = 8'hFF;

  typedef struct {
    cmd_t cmd;
    int   reps;
    bit   lit;
    res_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd_i = '0;
  logic res_valid_o;
  res_t res_o;

  res_t      pending_scores[$];
  res_t      oldest_score;
  stim_row_t stim_rows[$];
  int        mismatch_cnt = 0;
  int        beats_sent = 0;
  int        idle_cycles = 0;
  bit        no_idle = 1'b0;

  logic [CharW-1:0] ref_mem [MaxLen];
  int unsigned      ref_len = 0;
  bit               ref_closed = 1'b0;
  bit               ref_over = 1'b0;
  logic [CharW-1:0] q_prev = '0;
  int unsigned      q_len = 0;
  int unsigned      pair_matches = 0;
  bit               q_over = 1'b0;

  bigram_dice_similarity #(
    .MAX_LEN(MaxLen)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function automatic void clear_query();
    q_prev       = '0;
    q_len        = 0;
    pair_matches = 0;
    q_over       = 1'b0;
  endfunction

  function automatic void score_beat(input cmd_t c, output bit got, output res_t r);
    int unsigned pairs;
    int unsigned sc;
    int unsigned i;
    got = 1'b0;
    r   = '0;
    if (c.func == FUNC_REF) begin
      if (ref_closed) begin
        ref_len    = 0;
        ref_over   = 1'b0;
        ref_closed = 1'b0;
      end
      clear_query();
      if (ref_len < MaxLen) begin
        ref_mem[ref_len] = c.ch;
        ref_len++;
      end else begin
        ref_over = 1'b1;
      end
      if (c.last) ref_closed = 1'b1;
      return;
    end
    if (q_len < MaxLen) begin
      if (q_len >= 1) begin
        for (i = 1; i < ref_len; i++) begin
          if (ref_mem[i-1] == q_prev && ref_mem[i] == c.ch) pair_matches++;
        end
      end
      q_prev = c.ch;
      q_len++;
    end else begin
      q_over = 1'b1;
    end
    if (!c.last) return;
    if (ref_len < 2 || q_len < 2) begin
      r.status = STATUS_TOO_SHORT;
    end else if (ref_over || q_over) begin
      r.status = STATUS_TOO_LONG;
    end else begin
      pairs = ref_len + q_len - 2;
      sc    = (ScoreScale * pair_matches) / pairs;
      if (sc > 65535) sc = 65535;
      r.score  = sc[ScoreW-1:0];
      r.status = STATUS_OK;
    end
    clear_query();
    got = 1'b1;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CharW-1:0] pick_char(input int base, input int span);
    if (span >= 254) return CharW'($urandom_range(1, 255));
    return CharW'(base + $urandom_range(0, span));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 1;
    if (r < 86) return $urandom_range(2, 12);
    if (r < 93) return $urandom_range(13, 40);
    return $urandom_range(MaxLen - 2, MaxLen + 2);
  endfunction

  task automatic drive_beat(input cmd_t c, input bit use_lit, input res_t lit);
    bit   got;
    res_t guess;
    int   gap;
    start <= 1'b1;
    cmd_i <= c;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    score_beat(c, got, guess);
    if (got) pending_scores.push_back(use_lit ? lit : guess);
    beats_sent++;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_run(input logic func, input int len, input bit close,
                          input int base, input int span);
    cmd_t c;
    int   k;
    for (k = 0; k < len; k++) begin
      c.func = func;
      c.ch   = pick_char(base, span);
      c.last = close && (k == len - 1);
      drive_beat(c, 1'b0, '0);
    end
  endtask

  task automatic drain_scores();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_scores.size() != 0);
  endtask

  task automatic add_row(input logic func, input logic [CharW-1:0] ch, input logic last,
                         input int reps, input bit lit, input int score,
                         input logic [StatW-1:0] status);
    stim_row_t row;
    row.cmd.func    = func;
    row.cmd.ch      = ch;
    row.cmd.last    = last;
    row.reps        = reps;
    row.lit         = lit;
    row.want.score  = ScoreW'(score);
    row.want.status = status;
    stim_rows.push_back(row);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_scores.size() == 0) begin
        flag_mismatch($sformatf("unexpected result score=%0d status=%0d",
                                res_o.score, res_o.status));
      end else begin
        oldest_score = pending_scores.pop_front();
        if (res_o.score !== oldest_score.score)
          flag_mismatch($sformatf("score got %0d want %0d", res_o.score, oldest_score.score));
        if (res_o.status !== oldest_score.status)
          flag_mismatch($sformatf("status got %0d want %0d",
                                  res_o.status, oldest_score.status));
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : stim
    cmd_t c;
    int   n;
    int   k;
    int   kind;
    int   base;
    int   span;

    add_row(FUNC_QUERY, CH_A, 1'b1, 1, 1'b1, 0, STATUS_TOO_SHORT);
    add_row(FUNC_REF, CH_A, 1'b0, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_REF, CH_B, 1'b1, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_QUERY, CH_A, 1'b0, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_QUERY, CH_B, 1'b1, 1, 1'b1, 1000, STATUS_OK);
    add_row(FUNC_QUERY, CH_B, 1'b0, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_QUERY, CH_A, 1'b1, 1, 1'b1, 0, STATUS_OK);
    add_row(FUNC_REF, CH_MIN, 1'b0, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_REF, CH_MAX, 1'b1, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_QUERY, CH_MIN, 1'b0, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_QUERY, CH_MAX, 1'b1, 1, 1'b1, 1000, STATUS_OK);
    add_row(FUNC_QUERY, CH_MIN, 1'b1, 1, 1'b1, 0, STATUS_TOO_SHORT);
    add_row(FUNC_REF, CH_A, 1'b1, 3, 1'b0, 0, STATUS_OK);
    add_row(FUNC_QUERY, CH_A, 1'b1, 4, 1'b1, 2400, STATUS_OK);
    add_row(FUNC_QUERY, CH_A, 1'b0, 2, 1'b0, 0, STATUS_OK);
    add_row(FUNC_REF, CH_X, 1'b0, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_REF, CH_Y, 1'b1, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_QUERY, CH_X, 1'b0, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_QUERY, CH_Y, 1'b1, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_REF, CH_P, 1'b0, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_REF, CH_Q, 1'b0, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_QUERY, CH_P, 1'b0, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_QUERY, CH_Q, 1'b1, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_REF, CH_R, 1'b1, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_QUERY, CH_Q, 1'b0, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_QUERY, CH_R, 1'b1, 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_REF, CH_A, 1'b1, MaxLen + 1, 1'b0, 0, STATUS_OK);
    add_row(FUNC_QUERY, CH_A, 1'b1, 2, 1'b1, 0, STATUS_TOO_LONG);
    add_row(FUNC_QUERY, CH_A, 1'b1, 1, 1'b1, 0, STATUS_TOO_SHORT);
    add_row(FUNC_REF, CH_A, 1'b1, MaxLen, 1'b0, 0, STATUS_OK);
    add_row(FUNC_QUERY, CH_A, 1'b1, MaxLen, 1'b1, 63000, STATUS_OK);
    add_row(FUNC_QUERY, CH_A, 1'b1, MaxLen + 1, 1'b1, 0, STATUS_TOO_LONG);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      for (k = 0; k < stim_rows[i].reps; k++) begin
        c      = stim_rows[i].cmd;
        c.last = stim_rows[i].cmd.last && (k == stim_rows[i].reps - 1);
        drive_beat(c, stim_rows[i].lit, stim_rows[i].want);
      end
    end
    drain_scores();

    while (beats_sent < ItemTarget) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 3) begin
        span = 254;
        base = 1;
      end else begin
        span = $urandom_range(1, 3);
        base = $urandom_range(1, 255 - span);
      end
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        send_run(FUNC_REF, pick_len(), 1'b1, base, span);
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) send_run(FUNC_QUERY, pick_len(), 1'b1, base, span);
      end else if (kind < 88) begin
        send_run(FUNC_QUERY, $urandom_range(1, 6), 1'b0, base, span);
        send_run(FUNC_REF, pick_len(), 1'b1, base, span);
        send_run(FUNC_QUERY, pick_len(), 1'b1, base, span);
      end else if (kind < 94) begin
        send_run(FUNC_REF, pick_len(), 1'b0, base, span);
        send_run(FUNC_QUERY, pick_len(), 1'b1, base, span);
      end else begin
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) begin
          c.func = 1'($urandom_range(0, 1));
          c.ch   = CharW'($urandom_range(1, 255));
          c.last = 1'($urandom_range(0, 1));
          drive_beat(c, 1'b0, '0);
        end
      end
      if ($urandom_range(0, 19) == 0) drain_scores();
    end

    drain_scores();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/bds_pkg.sv
sv/bds_cell.sv
sv/bds_div.sv
sv/bigram_dice_similarity.sv
tb/sv/tb_top.sv
